// File: rtl/blr_pkg.sv
// Shared types and constants for the line brush rasterizer.
// No dependencies; compile first.
`default_nettype none

package blr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 24;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    // Brush beats in output order: centre, then the four diagonals.
    typedef enum logic [2:0] {
        BEAT_CENTER = 3'd0,
        BEAT_PP     = 3'd1,
        BEAT_MM     = 3'd2,
        BEAT_MP     = 3'd3,
        BEAT_PM     = 3'd4
    } t_beat;

endpackage : blr_pkg

`default_nettype wire

// File: rtl/blr_in_if.sv
// Command channel of the line brush rasterizer: load and step beats.
// Depends on blr_pkg.
`default_nettype none

interface blr_in_if
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] pen_color;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, pen_color,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, pen_color,
        output ready
    );
endinterface : blr_in_if

`default_nettype wire

// File: rtl/blr_out_if.sv
// Pixel write channel of the line brush rasterizer.
// Depends on blr_pkg.
`default_nettype none

interface blr_out_if
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS+1:0] pixel_x;
    logic signed [COORD_BITS+1:0] pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         line_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, line_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, line_done,
        output ready
    );
endinterface : blr_out_if

`default_nettype wire

// File: rtl/bresenham_line_brush_rasterizer.sv
// Bresenham line rasterizer with a five-pixel diagonal brush.
// Depends on blr_pkg, blr_in_if and blr_out_if.
//
// Usage:
//   i_cmd carries commands. A load beat (opcode 0) latches the end points
//   and color, sets up deltas, directions and error term and arms the line;
//   it produces no pixels. A step beat (opcode 1) on an armed line produces
//   five pixel beats on o_pix: the center, then (+1,+1), (-1,-1), (-1,+1),
//   (+1,-1). The last pixel of the end-point step carries line_done and the
//   line disarms. Steps on a disarmed line are taken and dropped.
//   The first pixel of a step is valid the cycle after the step beat is
//   taken. The line state advances at that same edge, so the next
//   command is taken in the cycle the fifth pixel leaves; the step rate
//   is bounded by the single pixel port. Loads and dropped steps produce
//   no pixels and do not hold up the next command.
//   Reset (i_rst_n low, synchronous) clears all line state, disarms the
//   line and empties the pixel register.
//   When the pixel receiver stalls, the current pixel holds and i_cmd.ready
//   stays low until the last pixel of the brush is taken.
`default_nettype none

module bresenham_line_brush_rasterizer
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    blr_in_if.sink     i_cmd,
    blr_out_if.source  o_pix
);

    localparam int OW = COORD_BITS + 2;

    // Line state
    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [COORD_BITS-1:0] r_abs_dx, r_abs_dy;
    logic                  r_x_back, r_y_back;
    logic signed [OW-1:0]  r_err;
    logic [COLOR_BITS-1:0] r_color;
    logic                  r_active;

    // Brush output register
    logic                  r_busy;
    t_beat                 r_beat;
    logic [COORD_BITS-1:0] r_bx, r_by;
    logic [COLOR_BITS-1:0] r_bcolor;
    logic                  r_bdone;

    logic cmd_acc, pix_acc, last_taken, is_step, is_load, at_end, step_x, step_y;
    logic                  step_go;
    logic                  n_x_back, n_y_back;
    logic [COORD_BITS-1:0] n_abs_dx, n_abs_dy;
    logic signed [OW-1:0]  n_err_init, n_err_step, e_dx, e_dy;
    logic signed [OW-1:0]  off_x, off_y;

    assign pix_acc    = o_pix.valid && o_pix.ready;
    assign last_taken = pix_acc && (r_beat == BEAT_PM);
    assign i_cmd.ready = !r_busy || last_taken;
    assign cmd_acc    = i_cmd.valid && i_cmd.ready;
    assign is_load    = (t_opcode'(i_cmd.opcode) == OP_LOAD);
    assign is_step    = (t_opcode'(i_cmd.opcode) == OP_STEP);
    assign step_go    = cmd_acc && is_step && r_active;

    // Load setup
    always_comb begin
        n_x_back = !(i_cmd.start_x < i_cmd.end_x);
        n_y_back = !(i_cmd.start_y < i_cmd.end_y);
        n_abs_dx = n_x_back ? (i_cmd.start_x - i_cmd.end_x) : (i_cmd.end_x - i_cmd.start_x);
        n_abs_dy = n_y_back ? (i_cmd.start_y - i_cmd.end_y) : (i_cmd.end_y - i_cmd.start_y);
        if (n_abs_dx > n_abs_dy) begin
            n_err_init = $signed({2'b00, n_abs_dx >> 1});
        end else begin
            n_err_init = -$signed({2'b00, n_abs_dy >> 1});
        end
    end

    // Step decision
    always_comb begin
        e_dx   = $signed({2'b00, r_abs_dx});
        e_dy   = $signed({2'b00, r_abs_dy});
        at_end = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
        step_x = (r_err > -e_dx);
        step_y = (r_err < e_dy);
        n_err_step = r_err - (step_x ? e_dy : '0) + (step_y ? e_dx : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_abs_dx <= '0;
            r_abs_dy <= '0;
            r_x_back <= 1'b0;
            r_y_back <= 1'b0;
            r_err    <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
            r_busy   <= 1'b0;
            r_beat   <= BEAT_CENTER;
        end else begin
            // A new brush only starts when idle or as the last beat leaves
            if (step_go) begin
                r_busy <= 1'b1;
                r_beat <= BEAT_CENTER;
            end else if (pix_acc) begin
                case (r_beat)
                    BEAT_CENTER: r_beat <= BEAT_PP;
                    BEAT_PP:     r_beat <= BEAT_MM;
                    BEAT_MM:     r_beat <= BEAT_MP;
                    BEAT_MP:     r_beat <= BEAT_PM;
                    default: begin
                        r_beat <= BEAT_CENTER;
                        r_busy <= 1'b0;
                    end
                endcase
            end
            if (cmd_acc && is_load) begin
                r_cur_x  <= i_cmd.start_x;
                r_cur_y  <= i_cmd.start_y;
                r_tgt_x  <= i_cmd.end_x;
                r_tgt_y  <= i_cmd.end_y;
                r_abs_dx <= n_abs_dx;
                r_abs_dy <= n_abs_dy;
                r_x_back <= n_x_back;
                r_y_back <= n_y_back;
                r_err    <= n_err_init;
                r_color  <= i_cmd.pen_color;
                r_active <= 1'b1;
            end else if (step_go) begin
                if (at_end) begin
                    r_active <= 1'b0;
                end else begin
                    r_err <= n_err_step;
                    if (step_x) begin
                        r_cur_x <= r_x_back ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                    end
                    if (step_y) begin
                        r_cur_y <= r_y_back ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                    end
                end
            end
        end
    end

    // Brush payload: capture the center as it stands before the advance
    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_bx     <= r_cur_x;
            r_by     <= r_cur_y;
            r_bcolor <= r_color;
            r_bdone  <= at_end;
        end
    end

    always_comb begin
        case (r_beat)
            BEAT_CENTER: begin off_x = '0;        off_y = '0;        end
            BEAT_PP:     begin off_x = OW'(1);    off_y = OW'(1);    end
            BEAT_MM:     begin off_x = '1;        off_y = '1;        end
            BEAT_MP:     begin off_x = '1;        off_y = OW'(1);    end
            default:     begin off_x = OW'(1);    off_y = '1;        end
        endcase
    end

    assign o_pix.valid       = r_busy;
    assign o_pix.pixel_x     = $signed({2'b00, r_bx}) + off_x;
    assign o_pix.pixel_y     = $signed({2'b00, r_by}) + off_y;
    assign o_pix.pixel_color = r_bcolor;
    assign o_pix.line_done   = r_bdone && (r_beat == BEAT_PM);

    // Checks
    a_done_last_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && o_pix.line_done |-> r_beat == BEAT_PM)
        else $error("line_done outside the last brush beat");

    a_step_starts_brush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc && is_step && r_active |=> r_busy && r_beat == BEAT_CENTER)
        else $error("armed step did not start a brush");

    a_done_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc && o_pix.line_done |-> !r_active)
        else $error("line still armed after its final pixel");

endmodule : bresenham_line_brush_rasterizer

`default_nettype wire
